[design/spectrum_bin_db_smooth_peak_hold_macros.svh]
// Assertion macros for the spectrum bin dB smoothing and peak hold block
`ifndef SPECTRUM_BIN_DB_SMOOTH_PEAK_HOLD_MACROS_SVH
`define SPECTRUM_BIN_DB_SMOOTH_PEAK_HOLD_MACROS_SVH
// implication checked every clock outside reset
`define SBDB_ASSERT_IMP(lbl, a, c) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (a) |-> (c)) \
    else $error("assertion failed");
// next-cycle implication
`define SBDB_ASSERT_NEXT(lbl, a, c) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (a) |=> (c)) \
    else $error("assertion failed");
`endif

[design/sbdb_pkg.sv]
// Package: shared types and constants for the spectrum bin dB block
`timescale 1ns / 1ps
package sbdb_pkg;
  localparam int unsigned AddrW = 12;
  localparam logic signed [31:0] DbScale = 32'sd101008905;
  localparam logic signed [15:0] MinDbRst = -16'sd20480;
  localparam logic [1:0] RegOrder = 2'd0;
  localparam logic [1:0] RegMinDb = 2'd1;
  localparam logic [1:0] RegMaxDb = 2'd2;
  localparam logic [1:0] RegHold = 2'd3;

  typedef struct packed {
    logic        tick;
    logic [11:0] bin;
    logic [31:0] mag;
  } item_t;

  typedef struct packed {
    logic [11:0]        bin;
    logic signed [15:0] level;
    logic signed [17:0] smooth;
    logic signed [15:0] peak;
    logic               active;
    logic               expired;
  } result_t;
endpackage

[design/sbdb_front.sv]
// Front end: two-entry queue of accepted items
`timescale 1ns / 1ps
module sbdb_front (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  input  sbdb_pkg::item_t in_item_i,
  output logic           q_valid_o,
  input  logic           q_ready_i,
  output sbdb_pkg::item_t q_item_o
);
  import sbdb_pkg::*;
  item_t     mem_q [2];
  logic      wp_q, rp_q, wp_d, rp_d;
  logic [1:0] cnt_q, cnt_d;
  logic      push, pop;

  assign in_ready_o = (cnt_q != 2'd2);
  assign q_valid_o = (cnt_q != 2'd0);
  assign q_item_o = mem_q[rp_q];
  assign push = in_valid_i && in_ready_o;
  assign pop = q_valid_o && q_ready_i;
  assign wp_d = push ? ~wp_q : wp_q;
  assign rp_d = pop ? ~rp_q : rp_q;
  assign cnt_d = cnt_q + {1'b0, push} - {1'b0, pop};

  always_ff @(posedge clk_i) begin
    if (push) mem_q[wp_q] <= in_item_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q <= 1'b0; rp_q <= 1'b0; cnt_q <= 2'd0;
    end else begin
      wp_q <= wp_d; rp_q <= rp_d; cnt_q <= cnt_d;
    end
  end
endmodule

[design/sbdb_back.sv]
// Back end: log conversion, bin store update and tick sweep
`timescale 1ns / 1ps
module sbdb_back #(
  parameter int unsigned MaxBins = 4096
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             q_valid_i,
  output logic             q_ready_o,
  input  sbdb_pkg::item_t  q_item_i,
  input  logic [3:0]       fft_order_i,
  input  logic signed [15:0] min_db_i,
  input  logic signed [15:0] max_db_i,
  input  logic [7:0]       hold_ticks_i,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output sbdb_pkg::result_t out_res_o
);
  import sbdb_pkg::*;
  `include "spectrum_bin_db_smooth_peak_hold_macros.svh"
  localparam int unsigned AW = $clog2(MaxBins);
  localparam int unsigned CW = AW + 1;

  localparam logic [3:0] S_IDLE = 4'd0, S_CLR = 4'd1, S_NORM = 4'd2, S_SQ = 4'd3,
    S_MUL = 4'd4, S_RND = 4'd5, S_RD = 4'd6, S_WB = 4'd7, S_OUT = 4'd8,
    S_TRD = 4'd9, S_TWB = 4'd10, S_RDW = 4'd11;

  logic [3:0] st_q, st_d;
  logic [CW-1:0] idx_q, idx_d;
  item_t it_q;
  logic [32:0] x_q;
  logic [4:0] e_q;
  logic [15:0] frac_q;
  logic [4:0] k_q;
  logic signed [22:0] l_q;
  logic signed [54:0] p_q;
  logic signed [15:0] lv_q;
  logic thr_q, exp_q;
  result_t res_q, res_d;
  logic ov_q, ov_d;
  logic res_load;

  logic signed [17:0] sm_mem [MaxBins];
  logic signed [15:0] pk_mem [MaxBins];
  logic [7:0] hd_mem [MaxBins];
  logic signed [17:0] sm_rd;
  logic signed [15:0] pk_rd;
  logic [7:0] hd_rd;
  logic [AW-1:0] raddr, waddr;
  logic we;
  logic signed [17:0] sm_wd;
  logic signed [15:0] pk_wd;
  logic [7:0] hd_wd;

  logic [CW-1:0] nbins;
  logic bin_live;
  logic [4:0] sh;
  logic [4:0] msb;
  logic [65:0] sq;
  logic [65:0] sqs;
  logic [46:0] m_x;
  logic [47:0] lim;
  logic [55:0] rnd_mag;
  logic signed [15:0] lvc;
  logic signed [17:0] snew;
  logic signed [15:0] pnew;
  logic [7:0] hnew;
  logic [7:0] hdec;

  // store-update results latched at write-back
  logic signed [17:0] snew_l;
  logic signed [15:0] pnew_l;
  logic [7:0] hnew_l;

  always_comb begin
    nbins = (fft_order_i == 4'd0) ? '0 : CW'(1) << (fft_order_i - 4'd1);
    if (fft_order_i >= 4'd1 && (32'd1 << (fft_order_i - 4'd1)) > MaxBins)
      nbins = CW'(MaxBins);
    bin_live = 32'(it_q.bin) < 32'(nbins);
    sh = 5'd14 + {1'b0, fft_order_i};
    msb = 5'd0;
    for (int i = 0; i < 32; i++) if (it_q.mag[i]) msb = 5'(i);
    sq = 66'(x_q) * 66'(x_q);
    sqs = sq >> 31;
    m_x = 47'(it_q.mag) * 47'd10000;
    lim = 48'd1 << sh;
    rnd_mag = (p_q < 0) ? 56'(-p_q) : 56'(p_q);
  end

  // saturated/clamped level from rounded product
  always_comb begin
    logic [24:0] r;
    logic signed [25:0] v;
    r = 25'((rnd_mag + 56'd2147483648) >> 32);
    v = (p_q < 0) ? -$signed({1'b0, r}) : $signed({1'b0, r});
    if (!thr_q) v = 26'(min_db_i);
    if (v < 26'(min_db_i)) lvc = min_db_i;
    else if (v > 26'(max_db_i)) lvc = max_db_i;
    else lvc = 16'(v);
  end

  always_comb begin
    logic signed [17:0] q;
    q = sm_rd >>> 2;
    snew = sm_rd - q + 18'(lv_q);
    if (lv_q > pk_rd) begin
      pnew = lv_q; hnew = hold_ticks_i;
    end else begin
      pnew = pk_rd; hnew = hd_rd;
    end
    hdec = (hd_rd != 8'd0) ? hd_rd - 8'd1 : hd_rd;
  end

  always_comb begin
    raddr = (st_q == S_TRD || st_q == S_TWB) ? idx_q[AW-1:0] : AW'(it_q.bin);
    waddr = idx_q[AW-1:0];
    we = 1'b0;
    sm_wd = snew; pk_wd = pnew; hd_wd = hnew;
    if (st_q == S_CLR) begin
      we = 1'b1; sm_wd = '0; pk_wd = MinDbRst; hd_wd = '0;
    end else if (st_q == S_WB) begin
      we = 1'b1; waddr = AW'(it_q.bin);
    end else if (st_q == S_TWB) begin
      we = 1'b1; sm_wd = sm_rd; hd_wd = hdec;
      pk_wd = (hd_rd == 8'd1) ? min_db_i : pk_rd;
    end
  end

  always_ff @(posedge clk_i) begin
    if (we) begin
      sm_mem[waddr] <= sm_wd; pk_mem[waddr] <= pk_wd; hd_mem[waddr] <= hd_wd;
    end
    sm_rd <= sm_mem[raddr]; pk_rd <= pk_mem[raddr]; hd_rd <= hd_mem[raddr];
  end

  always_comb begin
    st_d = st_q; idx_d = idx_q;
    unique case (st_q)
      S_CLR: begin
        idx_d = idx_q + 1'b1;
        if (idx_q == CW'(MaxBins - 1)) st_d = S_IDLE;
      end
      S_IDLE: if (q_valid_i) st_d = q_item_i.tick ? S_TRD : S_NORM;
      S_NORM: st_d = S_SQ;
      S_SQ: if (k_q == 5'd15) st_d = S_MUL;
      S_MUL: st_d = S_RND;
      S_RND: st_d = S_RD;
      S_RD: st_d = S_RDW;
      S_RDW: st_d = bin_live ? S_WB : S_OUT;
      S_WB: st_d = S_OUT;
      S_TRD: st_d = (idx_q >= nbins) ? S_OUT : S_TWB;
      S_TWB: begin idx_d = idx_q + 1'b1; st_d = S_TRD; end
      S_OUT: if (!ov_q || out_ready_i) st_d = S_IDLE;
      default: st_d = S_IDLE;
    endcase
    if (st_q == S_IDLE) idx_d = '0;
  end

  assign q_ready_o = (st_q == S_IDLE);

  always_ff @(posedge clk_i) begin
    if (st_q == S_IDLE && q_valid_i) begin
      it_q <= q_item_i; exp_q <= 1'b0;
    end
    if (st_q == S_NORM) begin
      e_q <= msb; x_q <= 33'(it_q.mag << (5'd31 - msb)); frac_q <= '0; k_q <= '0;
      thr_q <= 48'(m_x) > lim;
    end
    if (st_q == S_SQ) begin
      k_q <= k_q + 1'b1;
      if (sqs[32]) begin
        frac_q <= {frac_q[14:0], 1'b1}; x_q <= sqs[33:1];
      end else begin
        frac_q <= {frac_q[14:0], 1'b0}; x_q <= sqs[32:0];
      end
    end
    if (st_q == S_MUL) l_q <= $signed({2'b0, e_q, frac_q}) - $signed({2'b0, sh, 16'd0});
    if (st_q == S_RND) p_q <= 55'(l_q) * 55'(DbScale);
    if (st_q == S_RD) lv_q <= lvc;
    if (st_q == S_TWB && hd_rd == 8'd1) exp_q <= 1'b1;
  end

  assign res_load = (st_q == S_OUT) && (!ov_q || out_ready_i);
  assign ov_d = res_load || (ov_q && !out_ready_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= S_CLR; idx_q <= '0; ov_q <= 1'b0;
    end else begin
      st_q <= st_d; idx_q <= idx_d; ov_q <= ov_d;
    end
  end

  always_comb begin
    res_d = '0;
    if (it_q.tick) res_d.expired = exp_q;
    else begin
      res_d.bin = it_q.bin; res_d.level = lv_q;
      if (bin_live) begin
        res_d.smooth = snew_l; res_d.peak = pnew_l; res_d.active = hnew_l != 8'd0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_load) res_q <= res_d;
  end

  always_ff @(posedge clk_i) begin
    if (st_q == S_WB) begin
      snew_l <= snew; pnew_l <= pnew; hnew_l <= hnew;
    end
  end

  assign out_valid_o = ov_q;
  assign out_res_o = res_q;

  `SBDB_ASSERT_IMP(a_no_take_busy, q_ready_o, st_q == S_IDLE)
  `SBDB_ASSERT_NEXT(a_out_hold, out_valid_o && !out_ready_i, out_valid_o)
  `SBDB_ASSERT_IMP(a_we_state, we, st_q == S_CLR || st_q == S_WB || st_q == S_TWB)
endmodule

[design/spectrum_bin_db_smooth_peak_hold.sv]
// Top level: spectrum bin dB conversion, smoothing and peak hold
`timescale 1ns / 1ps
// Takes bin updates and hold ticks on a stream port and returns one result per
// item. After reset all MAX_BINS entries of the bin stores are cleared before the
// first item is taken. An update passes through the 16-step iterative log2
// squaring unit and the store read-modify-write; a tick walks the bin memory,
// reading and writing back each active bin.
module spectrum_bin_db_smooth_peak_hold #(
  parameter int unsigned MAX_BINS = 4096
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [47:0] s_axis_tdata,  // bin_index[11:0], magnitude[43:12], zero pad
  input  logic        s_axis_tuser,  // command
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [63:0] m_axis_tdata,  // out_bin, level_db, smoothed_db, peak_db,
                                     // peak_active, any_expired
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [15:0] cfg_data_i
);
  import sbdb_pkg::*;
  logic [3:0] order_q;
  logic signed [15:0] min_q, max_q;
  logic [7:0] hold_q;
  item_t in_item, q_item;
  result_t res;
  logic q_valid, q_ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      order_q <= 4'd11; min_q <= -16'sd20480; max_q <= '0; hold_q <= 8'd60;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        RegOrder: order_q <= cfg_data_i[3:0];
        RegMinDb: min_q <= cfg_data_i;
        RegMaxDb: max_q <= cfg_data_i;
        RegHold: hold_q <= cfg_data_i[7:0];
        default: ;
      endcase
    end
  end

  assign in_item = '{tick: s_axis_tuser, bin: s_axis_tdata[11:0], mag: s_axis_tdata[43:12]};

  sbdb_front u_front (
    .clk_i, .rst_ni, .in_valid_i(s_axis_tvalid), .in_ready_o(s_axis_tready),
    .in_item_i(in_item), .q_valid_o(q_valid), .q_ready_i(q_ready), .q_item_o(q_item)
  );

  sbdb_back #(.MaxBins(MAX_BINS)) u_back (
    .clk_i, .rst_ni, .q_valid_i(q_valid), .q_ready_o(q_ready), .q_item_i(q_item),
    .fft_order_i(order_q), .min_db_i(min_q), .max_db_i(max_q), .hold_ticks_i(hold_q),
    .out_valid_o(m_axis_tvalid), .out_ready_i(m_axis_tready), .out_res_o(res)
  );

  assign m_axis_tdata = {res.expired, res.active, res.peak, res.smooth, res.level, res.bin};
endmodule
